// ===== hdl/ckd_pkg.sv =====
// ----------------------------------------------------------------------------
// ckd_pkg
// Types, register indexes and small helper functions shared by the chroma key
// edge detector modules.
// ----------------------------------------------------------------------------
package ckd_pkg;

	// register indexes on the configuration port (byte address = 4 * index)
	localparam logic [2:0] REG_TARGET_C0    = 3'd0;
	localparam logic [2:0] REG_TARGET_C1    = 3'd1;
	localparam logic [2:0] REG_TARGET_C2    = 3'd2;
	localparam logic [2:0] REG_THRESHOLD_Q  = 3'd3;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

	localparam int ADDR_BITS = 5;
	localparam int DIST_W    = 10;
	localparam int POS_W     = 12;
	localparam int SIZE_W    = 13;

	localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd2;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

	localparam logic [7:0] MASK_ON  = 8'hff;
	localparam logic [7:0] MASK_OFF = 8'h00;

	// input pixel word
	typedef struct packed {
		logic [7:0] comp0;
		logic [7:0] comp1;
		logic [7:0] comp2;
	} pix_t;

	// output mask word
	typedef struct packed {
		logic [7:0]       edge_value;
		logic [POS_W-1:0] out_col;
		logic [POS_W-1:0] out_row;
		logic             last_of_run;
	} mask_t;

	// configuration register file contents
	typedef struct packed {
		logic [7:0]        target_c0;
		logic [7:0]        target_c1;
		logic [7:0]        target_c2;
		logic [9:0]        threshold_q;
		logic [SIZE_W-1:0] frame_width;
		logic [SIZE_W-1:0] frame_height;
	} cfg_t;

	// one pixel's results handed to the output serializer
	typedef struct packed {
		logic [7:0]       edge_value;
		logic [POS_W-1:0] col_m1;
		logic [POS_W-1:0] row_m1;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] wm1;
		logic             last_col;
		logic             last_row;
	} ser_load_t;

	function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
		absdiff8 = (a > b) ? (a - b) : (b - a);
	endfunction

	// L1 distance of a pixel to the key color, 0..765
	function automatic logic [DIST_W-1:0] l1_dist(input pix_t p, input cfg_t c);
		l1_dist = DIST_W'(absdiff8(p.comp0, c.target_c0))
			+ DIST_W'(absdiff8(p.comp1, c.target_c1))
			+ DIST_W'(absdiff8(p.comp2, c.target_c2));
	endfunction

endpackage

// ===== hdl/ckd_ram.sv =====
// ----------------------------------------------------------------------------
// ckd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ckd_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ckd_cfg.sv =====
// ----------------------------------------------------------------------------
// ckd_cfg
// APB-style configuration registers: key color, threshold and frame size.
// ----------------------------------------------------------------------------
module ckd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ckd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output ckd_pkg::cfg_t                 cfg
);

	ckd_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_c0    <= 8'd0;
			cfg_q.target_c1    <= 8'd0;
			cfg_q.target_c2    <= 8'd0;
			cfg_q.threshold_q  <= 10'd510;
			cfg_q.frame_width  <= 13'd1920;
			cfg_q.frame_height <= 13'd1080;
		end else if (wr_en) begin
			case (idx)
				ckd_pkg::REG_TARGET_C0:    cfg_q.target_c0    <= pwdata[7:0];
				ckd_pkg::REG_TARGET_C1:    cfg_q.target_c1    <= pwdata[7:0];
				ckd_pkg::REG_TARGET_C2:    cfg_q.target_c2    <= pwdata[7:0];
				ckd_pkg::REG_THRESHOLD_Q:  cfg_q.threshold_q  <= pwdata[9:0];
				ckd_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[12:0];
				ckd_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			ckd_pkg::REG_TARGET_C0:    prdata = {24'd0, cfg_q.target_c0};
			ckd_pkg::REG_TARGET_C1:    prdata = {24'd0, cfg_q.target_c1};
			ckd_pkg::REG_TARGET_C2:    prdata = {24'd0, cfg_q.target_c2};
			ckd_pkg::REG_THRESHOLD_Q:  prdata = {22'd0, cfg_q.threshold_q};
			ckd_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, cfg_q.frame_width};
			ckd_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, cfg_q.frame_height};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/ckd_ser.sv =====
// ----------------------------------------------------------------------------
// ckd_ser
// Output serializer: holds one pixel's mask value and emits its one to four
// words (self, last-column copy, last-row copy, corner copy).
// ----------------------------------------------------------------------------
module ckd_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ckd_pkg::ser_load_t load_data,
	output logic               free,
	output logic               mask_valid,
	input  logic               mask_ready,
	output ckd_pkg::mask_t     mask
);

	ckd_pkg::ser_load_t hold_q;
	logic               valid_q;
	// bit 0: column is the copy at w-1, bit 1: row is the current row
	logic [1:0]         code_q;
	logic               more_col;
	logic               more_row;
	logic               last;

	assign more_col   = hold_q.last_col && !code_q[0];
	assign more_row   = hold_q.last_row && !code_q[1];
	assign last       = !(more_col || more_row);
	assign free       = !valid_q || (mask_ready && last);
	assign mask_valid = valid_q;

	// output word from held fields
	always_comb begin
		mask.edge_value  = hold_q.edge_value;
		mask.out_col     = code_q[0] ? hold_q.wm1 : hold_q.col_m1;
		mask.out_row     = code_q[1] ? hold_q.row : hold_q.row_m1;
		mask.last_of_run = last;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			code_q  <= 2'b00;
		end else if (load) begin
			valid_q <= 1'b1;
			code_q  <= 2'b00;
		end else if (valid_q && mask_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else if (more_col) begin
				code_q <= code_q | 2'b01;
			end else begin
				code_q <= 2'b10;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			hold_q <= load_data;
		end
	end

endmodule

// ===== hdl/chroma_key_edge_detect.sv =====
// ----------------------------------------------------------------------------
// chroma_key_edge_detect
// Key color distance edge detector over a 2x2 window with a line buffer.
// ----------------------------------------------------------------------------
// Usage:
//   pix (valid/ready) takes one pixel word per cycle in raster order.
//   mask (valid/ready) gives mask words: 255 where a 2x2 window of key color
//   distances straddles the threshold, else 0. The last mask column and row
//   are copies of their neighbors, so pixels in the last column give two
//   words, pixels in the last row two, and the final pixel of a frame four.
//   Row 0 and column 0 pixels give no words.
//   A mask word is registered in stage 1 and then in the serializer.
//   Throughput: one pixel per cycle while the receiver takes words; each
//   extra word keeps the output serializer busy and so holds back the input.
//   The line buffer is one RAM with one write and one read port; a pixel
//   reads its column in the accept cycle and writes it back as stage 1 moves on.
//   Reset clears the position counters and window registers and loads the
//   default configuration; the line buffer is not cleared, the first row fills it.
//   A stalled receiver fills the serializer and then the stage in front of
//   it, after which pix_ready drops. Configure only while idle.
// ----------------------------------------------------------------------------
module chroma_key_edge_detect #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel channel
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  ckd_pkg::pix_t                 pix,
	// mask channel
	output logic                          mask_valid,
	input  logic                          mask_ready,
	output ckd_pkg::mask_t                mask,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ckd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int W_LIM  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam int DW     = ckd_pkg::DIST_W;
	localparam int PW     = ckd_pkg::POS_W;
	localparam int SW     = ckd_pkg::SIZE_W;

	ckd_pkg::cfg_t cfg;

	// configuration registers
	ckd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective frame size
	logic [SW-1:0] w_eff;
	logic [SW-1:0] h_eff;
	logic [SW-1:0] w_m1;
	logic [SW-1:0] h_m1;

	always_comb begin
		if (cfg.frame_width < ckd_pkg::SIZE_MIN) begin
			w_eff = ckd_pkg::SIZE_MIN;
		end else if (cfg.frame_width > SW'(W_LIM)) begin
			w_eff = SW'(W_LIM);
		end else begin
			w_eff = cfg.frame_width;
		end
		if (cfg.frame_height < ckd_pkg::SIZE_MIN) begin
			h_eff = ckd_pkg::SIZE_MIN;
		end else if (cfg.frame_height > ckd_pkg::SIZE_MAX) begin
			h_eff = ckd_pkg::SIZE_MAX;
		end else begin
			h_eff = cfg.frame_height;
		end
		w_m1 = w_eff - SW'(1);
		h_m1 = h_eff - SW'(1);
	end

	// accept stage: position counters
	logic [PW-1:0] col_q;
	logic [PW-1:0] row_q;
	logic          accept;
	logic          last_col;
	logic          last_row;

	assign accept   = pix_valid && pix_ready;
	assign last_col = col_q >= w_m1[PW-1:0];
	assign last_row = row_q >= h_m1[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	// stage 1 registers
	logic          s1_valid_q;
	logic          s1_new_q;
	logic [DW-1:0] dist_s1;
	logic [PW-1:0] col_s1;
	logic [PW-1:0] row_s1;
	logic [PW-1:0] wm1_s1;
	logic          last_col_s1;
	logic          last_row_s1;
	logic          has_res_s1;
	logic          s1_adv;
	logic          ser_free;
	logic          ser_load;

	assign s1_adv    = s1_valid_q && (!has_res_s1 || ser_free);
	assign pix_ready = !s1_valid_q || s1_adv;
	assign ser_load  = s1_adv && has_res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_new_q   <= 1'b0;
		end else begin
			s1_new_q <= accept;
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dist_s1     <= ckd_pkg::l1_dist(pix, cfg);
			col_s1      <= col_q;
			row_s1      <= row_q;
			wm1_s1      <= w_m1[PW-1:0];
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			has_res_s1  <= (col_q != '0) && (row_q != '0);
		end
	end

	// line buffer: read at accept, write back when stage 1 moves on
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DW-1:0]     ram_rdata;

	assign ram_re    = accept;
	assign ram_raddr = ADDR_W'(col_q);
	assign ram_we    = s1_adv;
	assign ram_waddr = ADDR_W'(col_s1);

	ckd_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (dist_s1),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// upper distance held while stage 1 waits
	logic [DW-1:0] up_hold_q;
	logic [DW-1:0] up;

	assign up = s1_new_q ? ram_rdata : up_hold_q;

	always_ff @(posedge clk) begin
		up_hold_q <= up;
	end

	// window registers
	logic [DW-1:0] left_q;
	logic [DW-1:0] upleft_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_adv) begin
			left_q   <= dist_s1;
			upleft_q <= up;
		end
	end

	// window min/max against the threshold
	logic [DW-1:0] mn_a;
	logic [DW-1:0] mn_b;
	logic [DW-1:0] mx_a;
	logic [DW-1:0] mx_b;
	logic [DW-1:0] mn;
	logic [DW-1:0] mx;
	logic [DW+1:0] thr;
	logic          is_edge;

	always_comb begin
		mn_a    = (upleft_q < up) ? upleft_q : up;
		mx_a    = (upleft_q < up) ? up : upleft_q;
		mn_b    = (left_q < dist_s1) ? left_q : dist_s1;
		mx_b    = (left_q < dist_s1) ? dist_s1 : left_q;
		mn      = (mn_a < mn_b) ? mn_a : mn_b;
		mx      = (mx_a < mx_b) ? mx_b : mx_a;
		thr     = {2'b00, cfg.threshold_q};
		is_edge = ({mn, 2'b00} <= thr) && (thr < {mx, 2'b00});
	end

	ckd_pkg::ser_load_t load_data;

	always_comb begin
		load_data.edge_value = is_edge ? ckd_pkg::MASK_ON : ckd_pkg::MASK_OFF;
		load_data.col_m1     = col_s1 - PW'(1);
		load_data.row_m1     = row_s1 - PW'(1);
		load_data.row        = row_s1;
		load_data.wm1        = wm1_s1;
		load_data.last_col   = last_col_s1;
		load_data.last_row   = last_row_s1;
	end

	// output serializer
	ckd_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (ser_load),
		.load_data  (load_data),
		.free       (ser_free),
		.mask_valid (mask_valid),
		.mask_ready (mask_ready),
		.mask       (mask)
	);

`ifndef SYNTHESIS
	// read and write-back never hit the same line entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("line buffer read and write to the same entry");

	// serializer is only loaded when it can take a new pixel
	a_ser_free: assert property (@(posedge clk) disable iff (!arst_n)
		ser_load |-> ser_free)
		else $error("serializer loaded while busy");

	// an accepted pixel sits in stage 1 on the next cycle with fresh read data
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (s1_valid_q && s1_new_q))
		else $error("accepted pixel lost before stage 1");
`endif

endmodule

// ===== dv/chroma_key_edge_detect_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chroma_key_edge_detect_tb
// Self-checking bench for the chroma key edge detector. Pixel words are fed
// from a backlog queue with random gaps. Every accepted pixel runs through a
// local model of the distance window and line buffer, and mask words are
// checked in order against what that model predicts. Key color, threshold
// and frame geometry change between runs. The runs include sizes below and
// above their limits, shrinks in the middle of a frame, a long receiver
// hold-off, and short runs with the frame sizes set past the top of their range.
// ----------------------------------------------------------------------------
module chroma_key_edge_detect_tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_PRINTS     = 40;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          pix_valid  = 1'b0;
	logic                          pix_ready;
	ckd_pkg::pix_t                 pix        = '0;
	logic                          mask_valid;
	logic                          mask_ready = 1'b0;
	ckd_pkg::mask_t                mask;
	logic                          psel       = 1'b0;
	logic                          penable    = 1'b0;
	logic                          pwrite     = 1'b0;
	logic [ckd_pkg::ADDR_BITS-1:0] paddr      = '0;
	logic [31:0]                   pwdata     = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	chroma_key_edge_detect uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.mask_valid (mask_valid),
		.mask_ready (mask_ready),
		.mask       (mask),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// bench state
	ckd_pkg::pix_t  pix_backlog[$];
	ckd_pkg::mask_t mask_due[$];
	logic  pix_fire       = 1'b0;
	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	int    hold_req       = 0;
	int    hold_seen      = 0;
	int    hold_left      = 0;
	int    stall_cycles   = 0;
	int    mismatches     = 0;

	// model copy of registers (reset values)
	logic [7:0]                 key_c0     = 8'd0;
	logic [7:0]                 key_c1     = 8'd0;
	logic [7:0]                 key_c2     = 8'd0;
	logic [9:0]                 thresh_q   = 10'd510;
	logic [ckd_pkg::SIZE_W-1:0] width_reg  = 13'd1920;
	logic [ckd_pkg::SIZE_W-1:0] height_reg = 13'd1080;

	// model copy of the window, line buffer and position
	logic [ckd_pkg::DIST_W-1:0] line_dist [0:4095] = '{default: '0};
	logic [ckd_pkg::DIST_W-1:0] left_d    = '0;
	logic [ckd_pkg::DIST_W-1:0] upleft_d  = '0;
	logic [ckd_pkg::POS_W-1:0]  col_cnt   = '0;
	logic [ckd_pkg::POS_W-1:0]  row_cnt   = '0;
	int                         line_fill = 0;	// columns of the line buffer written so far

	function automatic int eff_size(input logic [ckd_pkg::SIZE_W-1:0] v);
		if (v < ckd_pkg::SIZE_MIN)
			return ckd_pkg::SIZE_MIN;
		if (v > ckd_pkg::SIZE_MAX)
			return ckd_pkg::SIZE_MAX;
		return v;
	endfunction

	function automatic int comp_gap(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	task automatic push_mask(input logic [7:0] v, input int c, input int r);
		ckd_pkg::mask_t m;
		m.edge_value  = v;
		m.out_col     = ckd_pkg::POS_W'(c);
		m.out_row     = ckd_pkg::POS_W'(r);
		m.last_of_run = 1'b0;
		mask_due.push_back(m);
	endtask

	// mask words caused by one pixel, then the window and counters advance
	task automatic predict_mask_words(input ckd_pkg::pix_t p);
		int         w, h, d, up, lo, hi;
		int         win [3];
		bit         lc, lr;
		logic [7:0] v;
		w  = eff_size(width_reg);
		h  = eff_size(height_reg);
		// a count at or past the last index acts as the last index
		lc = (col_cnt >= w - 1);
		lr = (row_cnt >= h - 1);
		d  = comp_gap(p.comp0, key_c0) + comp_gap(p.comp1, key_c1)
			+ comp_gap(p.comp2, key_c2);
		up = line_dist[col_cnt];
		if (col_cnt != 0 && row_cnt != 0) begin
			win = '{up, left_d, d};
			lo  = upleft_d;
			hi  = upleft_d;
			foreach (win[i]) begin
				if (win[i] < lo)
					lo = win[i];
				if (win[i] > hi)
					hi = win[i];
			end
			v = (4 * lo <= thresh_q && thresh_q < 4 * hi) ? ckd_pkg::MASK_ON : ckd_pkg::MASK_OFF;
			push_mask(v, col_cnt - 1, row_cnt - 1);
			// last column and last row are copies
			if (lc)
				push_mask(v, w - 1, row_cnt - 1);
			if (lr)
				push_mask(v, col_cnt - 1, row_cnt);
			if (lr && lc)
				push_mask(v, w - 1, row_cnt);
			mask_due[mask_due.size() - 1].last_of_run = 1'b1;
		end
		upleft_d           = ckd_pkg::DIST_W'(up);
		left_d             = ckd_pkg::DIST_W'(d);
		line_dist[col_cnt] = ckd_pkg::DIST_W'(d);
		if (col_cnt + 1 > line_fill)
			line_fill = col_cnt + 1;
		if (lc) begin
			col_cnt = '0;
			row_cnt = lr ? '0 : row_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [ckd_pkg::POS_W-1:0] got,
			input logic [ckd_pkg::POS_W-1:0] exp_v, input ckd_pkg::mask_t want);
		if (got !== exp_v)
			report_mismatch($sformatf("%s of mask (%0d,%0d): got %0d, expected %0d",
				name, want.out_col, want.out_row, got, exp_v));
	endtask

	// pixel driver: next word once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_fire)) begin
			if (pix_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pix       <= pix_backlog.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// mask receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen  <= hold_req;
			hold_left  <= HOLD_CYCLES;
			mask_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left  <= hold_left - 1;
			mask_ready <= 1'b0;
		end else begin
			mask_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on accepted pixels, check accepted mask words
	always @(posedge clk) begin : monitor
		ckd_pkg::mask_t want;
		pix_fire <= pix_valid && pix_ready;
		if (pix_valid && pix_ready)
			predict_mask_words(pix);
		if (mask_valid && mask_ready) begin
			if (mask_due.size() == 0) begin
				report_mismatch($sformatf("mask word %0d at (%0d,%0d) with none due",
					mask.edge_value, mask.out_col, mask.out_row));
			end else begin
				want = mask_due.pop_front();
				check_field("edge_value", mask.edge_value, want.edge_value, want);
				check_field("out_col", mask.out_col, want.out_col, want);
				check_field("out_row", mask.out_row, want.out_row, want);
				check_field("last_of_run", mask.last_of_run, want.last_of_run, want);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (mask_valid && mask_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("chroma_key_edge_detect verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// wait until every pixel is taken and every mask word is in, then drain
	task automatic settle();
		do
			@(posedge clk);
		while (pix_backlog.size() != 0 || pix_valid || mask_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write: setup cycle, then access cycle
	task automatic write_reg(input logic [2:0] idx, input int unsigned val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ckd_pkg::ADDR_BITS'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			ckd_pkg::REG_TARGET_C0:    key_c0     = val[7:0];
			ckd_pkg::REG_TARGET_C1:    key_c1     = val[7:0];
			ckd_pkg::REG_TARGET_C2:    key_c2     = val[7:0];
			ckd_pkg::REG_THRESHOLD_Q:  thresh_q   = val[9:0];
			ckd_pkg::REG_FRAME_WIDTH:  width_reg  = val[ckd_pkg::SIZE_W-1:0];
			ckd_pkg::REG_FRAME_HEIGHT: height_reg = val[ckd_pkg::SIZE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_idle(input idle_mode_t m);
		case (m)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 72; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 72; end
			IDLE_BOTH: begin send_idle_pct = 14; recv_stall_pct = 14; end
			default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endtask

	function automatic logic [7:0] near_comp(input logic [7:0] k);
		int t;
		t = int'(k) + int'($urandom_range(16)) - 8;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	function automatic logic [7:0] pick_comp();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(255));
	endfunction

	// pixels on, near or far from the key so windows straddle the threshold
	function automatic ckd_pkg::pix_t rand_pix();
		ckd_pkg::pix_t p;
		case ($urandom_range(3))
			0: p = '{key_c0, key_c1, key_c2};
			1: p = '{near_comp(key_c0), near_comp(key_c1), near_comp(key_c2)};
			2: p = '{8'($urandom), 8'($urandom), 8'($urandom)};
			default: p = '{$urandom_range(1) ? 8'd255 : 8'd0,
				$urandom_range(1) ? 8'd255 : 8'd0, $urandom_range(1) ? 8'd255 : 8'd0};
		endcase
		return p;
	endfunction

	task automatic queue_one(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
		pix_backlog.push_back(ckd_pkg::pix_t'{c0, c1, c2});
	endtask

	task automatic queue_pixels(input int n);
		repeat (n) pix_backlog.push_back(rand_pix());
	endtask

	// random register subset; width only grows where the line buffer is filled
	task automatic random_config();
		int w;
		if ($urandom_range(1))
			write_reg(ckd_pkg::REG_TARGET_C0, pick_comp());
		if ($urandom_range(1))
			write_reg(ckd_pkg::REG_TARGET_C1, pick_comp());
		if ($urandom_range(1))
			write_reg(ckd_pkg::REG_TARGET_C2, pick_comp());
		if ($urandom_range(1)) begin
			case ($urandom_range(4))
				0: write_reg(ckd_pkg::REG_THRESHOLD_Q, 0);
				1: write_reg(ckd_pkg::REG_THRESHOLD_Q, 1020);
				2: write_reg(ckd_pkg::REG_THRESHOLD_Q, 1023);
				3: write_reg(ckd_pkg::REG_THRESHOLD_Q, $urandom_range(1023));
				default: write_reg(ckd_pkg::REG_THRESHOLD_Q, $urandom_range(150, 800));
			endcase
		end
		w = ($urandom_range(4) == 0) ? $urandom_range(0, 12) : $urandom_range(2, 8);
		if ($urandom_range(1) &&
				(row_cnt == 0 || eff_size(ckd_pkg::SIZE_W'(w)) <= line_fill))
			write_reg(ckd_pkg::REG_FRAME_WIDTH, w);
		if ($urandom_range(1))
			write_reg(ckd_pkg::REG_FRAME_HEIGHT, $urandom_range(0, 6));
	endtask

	// complete the frame in progress so the next one starts at the origin
	task automatic finish_frame();
		int c, r, w, h, n;
		settle();
		w = eff_size(width_reg);
		h = eff_size(height_reg);
		c = col_cnt;
		r = row_cnt;
		n = 0;
		while (c != 0 || r != 0) begin
			if (c >= w - 1) begin
				c = 0;
				r = (r >= h - 1) ? 0 : r + 1;
			end else begin
				c++;
			end
			n++;
		end
		queue_pixels(n);
		settle();
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// component extremes in row 0 of the reset geometry: no words yet
		queue_one(8'd0, 8'd0, 8'd0);
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd255, 8'd0, 8'd0);
		queue_one(8'd0, 8'd255, 8'd0);
		queue_one(8'd0, 8'd0, 8'd255);
		queue_one(8'h55, 8'haa, 8'h0f);
		settle();

		// sizes below the minimum clamp to 2; column count is now past the end
		write_reg(ckd_pkg::REG_TARGET_C0, 255);
		write_reg(ckd_pkg::REG_TARGET_C1, 0);
		write_reg(ckd_pkg::REG_TARGET_C2, 128);
		write_reg(ckd_pkg::REG_THRESHOLD_Q, 0);
		write_reg(ckd_pkg::REG_FRAME_WIDTH, 0);
		write_reg(ckd_pkg::REG_FRAME_HEIGHT, 1);
		queue_one(8'd255, 8'd0, 8'd128);
		queue_one(8'd0, 8'd0, 8'd0);
		queue_one(8'd255, 8'd0, 8'd128);
		// flat frame on the key: no edge at zero threshold
		repeat (4) queue_one(8'd255, 8'd0, 8'd128);
		settle();

		// threshold at 1020, then at 1023, the top of its 10-bit range
		write_reg(ckd_pkg::REG_THRESHOLD_Q, 1020);
		queue_one(8'd255, 8'd0, 8'd128);
		queue_one(8'd0, 8'd255, 8'd255);
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd0, 8'd0, 8'd0);
		settle();
		write_reg(ckd_pkg::REG_THRESHOLD_Q, 1023);
		queue_one(8'd0, 8'd255, 8'd255);
		queue_one(8'd255, 8'd0, 8'd128);
		queue_one(8'd255, 8'd0, 8'd128);
		queue_one(8'd0, 8'd255, 8'd0);
		settle();

		// receiver holds off while pixels keep coming: input must back up
		set_idle(IDLE_NONE);
		write_reg(ckd_pkg::REG_FRAME_WIDTH, 6);
		write_reg(ckd_pkg::REG_FRAME_HEIGHT, 4);
		hold_req++;
		queue_pixels(40);
		settle();

		// random runs over the idling modes; runs end mid-frame
		for (int ph = 0; ph < 10; ph++) begin
			set_idle(idle_mode_t'(ph % 4));
			random_config();
			queue_pixels($urandom_range(8, 20));
			settle();
		end

		// height past the top of its range, then close the frame with a short height
		set_idle(IDLE_NONE);
		finish_frame();
		write_reg(ckd_pkg::REG_FRAME_WIDTH, 2);
		write_reg(ckd_pkg::REG_FRAME_HEIGHT, 8191);
		queue_pixels(24);
		settle();
		write_reg(ckd_pkg::REG_FRAME_HEIGHT, 0);
		finish_frame();

		// width past the top of its range: a stretch of row 0, no words
		write_reg(ckd_pkg::REG_FRAME_WIDTH, 5000);
		queue_pixels(16);
		settle();

		if (mismatches == 0)
			$display("chroma_key_edge_detect verification clean");
		else
			$display("chroma_key_edge_detect verification failed");
		$finish;
	end

endmodule
